### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frame decoder checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CLD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define CLD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/cld_pkg.sv
// ----------------------------------------------------------------------------
// cld_pkg
// Types and constants shared by the camera link frame decoder modules.
// ----------------------------------------------------------------------------
package cld_pkg;

  // frame store depth and derived widths
  localparam int FRAME_MAX = 6;
  localparam int IDX_W     = $clog2(FRAME_MAX);
  localparam int CNT_W     = $clog2(FRAME_MAX + 1);

  // classified-request queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam int BYTE_W = 8;
  localparam int COORD_W = 9;
  localparam int OUT_W  = 40;

  // register reset values
  localparam logic [BYTE_W-1:0] HEAD_RESET = 8'd10;
  localparam logic [BYTE_W-1:0] TAIL_RESET = 8'd0;

  // mode command characters
  localparam logic [BYTE_W-1:0] CHAR_L = 8'h4C;
  localparam logic [BYTE_W-1:0] CHAR_R = 8'h52;
  localparam logic [BYTE_W-1:0] CHAR_D = 8'h44;
  localparam logic [BYTE_W-1:0] CHAR_F = 8'h46;

  localparam logic [BYTE_W-1:0] DETECT_FOUND = 8'd1;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_MODE = 2'd1,
    OP_UART = 2'd2
  } op_t;

  typedef enum logic [0:0] {
    CFG_HEAD = 1'b0,
    CFG_TAIL = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_RESET  = 2'd0,
    MODE_DETECT = 2'd1,
    MODE_LOCATE = 2'd2,
    MODE_PUT    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    KIND_HEAD,
    KIND_TAIL,
    KIND_DATA,
    KIND_MODE,
    KIND_IDLE
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  send_byte;
    logic               send_valid;
    logic               overflow;
    logic               frame_done;
    mode_t              current_mode;
    logic               detected;
    logic [BYTE_W-1:0]  picture_number;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_x;
  } result_t;

endpackage

### src/cld_front.sv
// ----------------------------------------------------------------------------
// cld_front
// Holds the head/tail registers and classifies each incoming request.
// ----------------------------------------------------------------------------
module cld_front import cld_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [0:0]        cfg_index,
  input  logic [BYTE_W-1:0] cfg_wdata,
  input  logic [1:0]        op,
  input  logic [BYTE_W-1:0] value,
  output item_t             item
);

  logic [BYTE_W-1:0] head_r;
  logic [BYTE_W-1:0] tail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= HEAD_RESET;
      tail_r <= TAIL_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_HEAD: head_r <= cfg_wdata;
        CFG_TAIL: tail_r <= cfg_wdata;
      endcase
    end
  end

  // head wins over tail when both match
  always_comb begin
    item.value = value;
    unique case (op_t'(op))
      OP_BYTE: begin
        if (value == head_r)      item.kind = KIND_HEAD;
        else if (value == tail_r) item.kind = KIND_TAIL;
        else                      item.kind = KIND_DATA;
      end
      OP_MODE: item.kind = KIND_MODE;
      default: item.kind = KIND_IDLE;
    endcase
  end

endmodule

### src/cld_queue.sv
// ----------------------------------------------------------------------------
// cld_queue
// Small first-word-fall-through queue of classified requests.
// ----------------------------------------------------------------------------
module cld_queue import cld_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  full,
  output logic  not_empty,
  output item_t head_item
);

  item_t               slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CW-1:0] count_r, count_nxt;

  assign full      = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_item = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_r + 1'b1;
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_item;
  end

endmodule

### src/cld_back.sv
// ----------------------------------------------------------------------------
// cld_back
// Deframing, frame decode and result register.
// ----------------------------------------------------------------------------
module cld_back import cld_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_not_empty,
  input  item_t   q_item,
  output logic    q_pop,
  input  logic    res_ready,
  output logic    res_valid,
  output result_t res
);

  logic               cap_r, cap_nxt;
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  logic [BYTE_W-1:0]  store_r [FRAME_MAX];
  mode_t              mode_r, mode_nxt;
  logic [COORD_W-1:0] x_r, x_nxt;
  logic [COORD_W-1:0] y_r, y_nxt;
  logic [BYTE_W-1:0]  pic_r, pic_nxt;
  logic               found_r, found_nxt;
  logic               res_valid_r, res_valid_nxt;
  result_t            res_r, res_nxt;

  logic               wr_en;
  logic [CNT_W-1:0]   cnt_inc;
  logic               done, ovf, sv;
  logic [BYTE_W-1:0]  sb;
  logic [COORD_W-1:0] x_scaled, y_scaled;

  assign q_pop     = q_not_empty && (!res_valid_r || res_ready);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  // byte * 1.5 truncated = b + (b >> 1)
  assign x_scaled = {1'b0, store_r[2]} + {2'b00, store_r[2][BYTE_W-1:1]};
  assign y_scaled = {1'b0, store_r[3]} + {2'b00, store_r[3][BYTE_W-1:1]};
  assign cnt_inc  = CNT_W'(cnt_r) + CNT_W'(1);

  always_comb begin
    cap_nxt   = cap_r;
    cnt_nxt   = cnt_r;
    mode_nxt  = mode_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    pic_nxt   = pic_r;
    found_nxt = found_r;
    done      = 1'b0;
    ovf       = 1'b0;
    sv        = 1'b0;
    sb        = '0;
    wr_en     = 1'b0;

    unique case (q_item.kind)
      KIND_HEAD: cap_nxt = 1'b1;
      KIND_TAIL: begin
        done    = 1'b1;
        cap_nxt = 1'b0;
        cnt_nxt = '0;
        unique case (mode_r)
          MODE_LOCATE: begin
            x_nxt = x_scaled;
            y_nxt = y_scaled;
          end
          MODE_DETECT: begin
            if (store_r[1] == DETECT_FOUND) begin
              x_nxt     = x_scaled;
              y_nxt     = y_scaled;
              found_nxt = 1'b1;
              mode_nxt  = MODE_RESET;
              sv        = 1'b1;
              sb        = CHAR_R;
            end
          end
          MODE_PUT: begin
            x_nxt   = x_scaled;
            y_nxt   = y_scaled;
            pic_nxt = store_r[4];
          end
          MODE_RESET: ;
        endcase
      end
      KIND_MODE: begin
        sv = 1'b1;
        sb = q_item.value;
        unique case (q_item.value)
          CHAR_L:  mode_nxt = MODE_LOCATE;
          CHAR_R:  mode_nxt = MODE_RESET;
          CHAR_D:  mode_nxt = MODE_DETECT;
          CHAR_F:  mode_nxt = MODE_PUT;
          default: mode_nxt = mode_r;
        endcase
      end
      default: ;
    endcase

    // store while capturing; a tail byte has already closed capture
    if ((q_item.kind == KIND_HEAD || q_item.kind == KIND_DATA) && cap_nxt) begin
      wr_en = 1'b1;
      if (cnt_inc >= CNT_W'(FRAME_MAX)) begin
        ovf     = 1'b1;
        cnt_nxt = '0;
        cap_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_inc[IDX_W-1:0];
      end
    end

    res_nxt.coord_x        = x_nxt;
    res_nxt.coord_y        = y_nxt;
    res_nxt.picture_number = pic_nxt;
    res_nxt.detected       = found_nxt;
    res_nxt.current_mode   = mode_nxt;
    res_nxt.frame_done     = done;
    res_nxt.overflow       = ovf;
    res_nxt.send_valid     = sv;
    res_nxt.send_byte      = sb;

    if (q_pop)          res_valid_nxt = 1'b1;
    else if (res_ready) res_valid_nxt = 1'b0;
    else                res_valid_nxt = res_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= 1'b0;
      cnt_r       <= '0;
      mode_r      <= MODE_RESET;
      x_r         <= '0;
      y_r         <= '0;
      pic_r       <= '0;
      found_r     <= 1'b0;
      res_valid_r <= 1'b0;
      for (int i = 0; i < FRAME_MAX; i++) store_r[i] <= '0;
    end else begin
      res_valid_r <= res_valid_nxt;
      if (q_pop) begin
        cap_r   <= cap_nxt;
        cnt_r   <= cnt_nxt;
        mode_r  <= mode_nxt;
        x_r     <= x_nxt;
        y_r     <= y_nxt;
        pic_r   <= pic_nxt;
        found_r <= found_nxt;
        if (wr_en) store_r[cnt_r] <= q_item.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) res_r <= res_nxt;
  end

endmodule

### src/camera_link_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// camera_link_frame_decoder_core
// Deframes camera link bytes and decodes position / picture frames.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per transfer. in_tuser is the op (0 received byte,
//           1 mode command, 2/3 no effect), in_tdata the byte or mode char.
//   out_* : exactly one result per request, in order, 40-bit tdata.
//   cfg_* : head byte (index 0) and tail byte (index 1); the user writes
//           them only while the block is idle (not enforced); no read-back.
// Path: an accepted request is written into the request queue, then decoded
//   into the result register when popped, which raises out_tvalid.
// Throughput: one request per cycle while results are taken; the back end
//   updates all state for one request at once.
// Reset: synchronous; head = 10, tail = 0, frame store, count, mode,
//   coordinates, picture number and detect flag all cleared.
// Stall: a held result stays in the output register; the two-entry
//   request queue keeps taking input until it fills, then in_tready drops.
// ----------------------------------------------------------------------------
module camera_link_frame_decoder_core import cld_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_wr_en,
  input  logic [0:0]        cfg_index,
  input  logic [BYTE_W-1:0] cfg_wdata,
  // request channel
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [BYTE_W-1:0] in_tdata,   // [7:0] value
  input  logic [1:0]        in_tuser,   // [1:0] op
  // result channel
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata   // [8:0] coord_x, [17:9] coord_y,
                                        // [25:18] picture_number, [26] detected,
                                        // [28:27] current_mode, [29] frame_done,
                                        // [30] overflow, [31] send_valid,
                                        // [39:32] send_byte
);

  item_t   front_item;   // classified request from the front end
  item_t   q_item;
  logic    q_full, q_not_empty, q_pop, push;
  result_t res;

  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;

  cld_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .op        (in_tuser),
    .value     (in_tdata),
    .item      (front_item)
  );

  // decouples acceptance from the decode/result stage
  cld_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_item (q_item)
  );

  cld_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .res_ready   (out_tready),
    .res_valid   (out_tvalid),
    .res         (res)
  );

  // result_t packs send_byte at the top and coord_x at the bottom
  assign out_tdata = res;

endmodule

### src/cld_checker.sv
// ----------------------------------------------------------------------------
// cld_checker
// Port-level assertions for camera_link_frame_decoder_core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cld_checker import cld_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_W-1:0]  out_tdata
);

  logic detected_seen_r, detected_seen_nxt;
  logic out_acc;

  assign out_acc = out_tvalid && out_tready;

  always_comb begin
    detected_seen_nxt = detected_seen_r || (out_acc && out_tdata[26]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) detected_seen_r <= 1'b0;
    else        detected_seen_r <= detected_seen_nxt;
  end

  `CLD_ASSERT_IMP(a_send_zero, clk, rst_n, out_tvalid && !out_tdata[31], out_tdata[39:32] == '0, "send_byte nonzero without send_valid")
  `CLD_ASSERT_IMP(a_done_ovf, clk, rst_n, out_tvalid, !(out_tdata[29] && out_tdata[30]), "frame_done and overflow together")
  `CLD_ASSERT_IMP(a_detect_send, clk, rst_n, out_tvalid && out_tdata[29] && out_tdata[31], out_tdata[39:32] == CHAR_R && out_tdata[28:27] == MODE_RESET, "decode send is not a reset command")
  `CLD_ASSERT_IMP(a_sticky, clk, rst_n, out_tvalid && detected_seen_r, out_tdata[26], "detected flag cleared")
  `CLD_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

endmodule

bind camera_link_frame_decoder_core cld_checker u_cld_checker (.*);

### tb/sv/cld_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cld_frame_checker
// Watches the request, result and register ports of the frame decoder,
// predicts each result from its own copy of the decoder state, and compares
// the results field by field in order.
// ----------------------------------------------------------------------------
module cld_frame_checker import cld_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [0:0]        cfg_index,
  input  logic [BYTE_W-1:0] cfg_wdata,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [BYTE_W-1:0] in_tdata,
  input  logic [1:0]        in_tuser,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_W-1:0]  out_tdata,
  output int                fail_count,
  output int                pending,
  output int                checked,
  output int                frames,
  output int                overflows,
  output int                finds
);

  // shadow of the decoder state
  logic [BYTE_W-1:0]  head_q;
  logic [BYTE_W-1:0]  tail_q;
  logic               capturing;
  logic [CNT_W-1:0]   fill;
  logic [BYTE_W-1:0]  store [FRAME_MAX];
  mode_t              mode_q;
  logic [COORD_W-1:0] x_q;
  logic [COORD_W-1:0] y_q;
  logic [BYTE_W-1:0]  pic_q;
  logic               found_q;

  result_t            expected_q [$];

  // byte * 1.5, truncated
  function automatic logic [COORD_W-1:0] times_1p5(input logic [BYTE_W-1:0] b);
    logic [COORD_W:0] t;
    t = {2'b00, b} * 10'd3;
    return t[COORD_W:1];
  endfunction

  task automatic load_xy();
    x_q = times_1p5(store[2]);
    y_q = times_1p5(store[3]);
  endtask

  task automatic predict_result(input logic [1:0] op, input logic [BYTE_W-1:0] v);
    result_t r;
    r = '0;
    if (op == OP_BYTE) begin
      if (v == head_q) begin
        capturing = 1'b1;
      end else if (v == tail_q) begin
        r.frame_done = 1'b1;
        frames++;
        case (mode_q)
          MODE_LOCATE: load_xy();
          MODE_DETECT: begin
            if (store[1] == DETECT_FOUND) begin
              load_xy();
              found_q      = 1'b1;
              mode_q       = MODE_RESET;
              r.send_valid = 1'b1;
              r.send_byte  = CHAR_R;
              finds++;
            end
          end
          MODE_PUT: begin
            load_xy();
            pic_q = store[4];
          end
          default: ;
        endcase
        capturing = 1'b0;
        fill      = '0;
      end
      if (capturing) begin
        store[fill] = v;
        fill++;
        if (fill >= FRAME_MAX) begin
          r.overflow = 1'b1;
          overflows++;
          fill      = '0;
          capturing = 1'b0;
        end
      end
    end else if (op == OP_MODE) begin
      r.send_valid = 1'b1;
      r.send_byte  = v;
      case (v)
        CHAR_L:  mode_q = MODE_LOCATE;
        CHAR_R:  mode_q = MODE_RESET;
        CHAR_D:  mode_q = MODE_DETECT;
        CHAR_F:  mode_q = MODE_PUT;
        default: ;
      endcase
    end
    r.coord_x        = x_q;
    r.coord_y        = y_q;
    r.picture_number = pic_q;
    r.detected       = found_q;
    r.current_mode   = mode_q;
    expected_q.push_back(r);
  endtask

  task automatic compare_field(input string fname, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("[%0t] result %0d: %s expected %0d, got %0d",
                 $time, checked, fname, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    if (!rst_n) begin
      head_q    = HEAD_RESET;
      tail_q    = TAIL_RESET;
      capturing = 1'b0;
      fill      = '0;
      foreach (store[i]) store[i] = '0;
      mode_q    = MODE_RESET;
      x_q       = '0;
      y_q       = '0;
      pic_q     = '0;
      found_q   = 1'b0;
      expected_q.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_HEAD) head_q = cfg_wdata;
        else tail_q = cfg_wdata;
      end
      // results first: a result leaving now belongs to an earlier request
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        checked++;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] result %0d with no request waiting: %h", $time, checked, got);
        end else begin
          want = expected_q.pop_front();
          compare_field("coord_x", 32'(want.coord_x), 32'(got.coord_x));
          compare_field("coord_y", 32'(want.coord_y), 32'(got.coord_y));
          compare_field("picture_number", 32'(want.picture_number),
                        32'(got.picture_number));
          compare_field("detected", 32'(want.detected), 32'(got.detected));
          compare_field("current_mode", 32'(want.current_mode),
                        32'(got.current_mode));
          compare_field("frame_done", 32'(want.frame_done), 32'(got.frame_done));
          compare_field("overflow", 32'(want.overflow), 32'(got.overflow));
          compare_field("send_valid", 32'(want.send_valid), 32'(got.send_valid));
          compare_field("send_byte", 32'(want.send_byte), 32'(got.send_byte));
        end
      end
      if (in_tvalid && in_tready) predict_result(in_tuser, in_tdata);
    end
    pending = expected_q.size();
  end

endmodule

### tb/sv/camera_link_frame_decoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_link_frame_decoder_core_tb
// Drives received bytes, mode commands and idle events into the frame
// decoder under several head / tail settings, with bursty requests and a
// stalling result side; the checker module predicts and compares results.
// ----------------------------------------------------------------------------
module camera_link_frame_decoder_core_tb import cld_pkg::*;;

  // op value with no package name; the block treats it as a no-op
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam int PHASES       = 5;
  localparam int PHASE_REQS   = 225;     // random requests per register setting
  localparam int HOLD_CYCLES  = 120;     // long result-side hold-off
  localparam int SETTLE       = 4;       // cycles after the last result before cfg writes
  localparam int DRAIN        = 20;      // quiet cycles at the end
  localparam int LIMIT_CYCLES = 200000;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [0:0]        cfg_index;
  logic [BYTE_W-1:0] cfg_wdata;
  logic              in_tvalid;
  logic              in_tready;
  logic [BYTE_W-1:0] in_tdata;
  logic [1:0]        in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;

  int fail_count, pending, checked, frames, overflows, finds;

  // stimulus bookkeeping
  int                req_count  = 0;
  int                burst_left = 0;
  int                settings   = 1;
  int                cycles     = 0;
  bit                hold_req   = 1'b0;
  logic [BYTE_W-1:0] head_val;
  logic [BYTE_W-1:0] tail_val;
  logic [BYTE_W-1:0] mode_chars [4] = '{CHAR_L, CHAR_R, CHAR_D, CHAR_F};

  camera_link_frame_decoder_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  cld_frame_checker i_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .frames     (frames),
    .overflows  (overflows),
    .finds      (finds)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog: a hung handshake or a lost result ends here
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still expected", cycles, pending);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: ready follows a stall style picked at random for each run of
  // cycles (always ready, coin flip, mostly ready, mostly stalled). When the
  // stimulus asks for it, ready is held low for HOLD_CYCLES, counted here,
  // so the request queue fills and in_tready drops.
  initial begin : result_sink
    int style;
    int left;
    int held;
    style      = 0;
    left       = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(negedge clk);
          held++;
        end
        hold_req = 1'b0;
      end
      if (left == 0) begin
        style = $urandom_range(0, 3);
        left  = $urandom_range(16, 96);
      end
      left--;
      case (style)
        0:       out_tready = 1'b1;
        1:       out_tready = 1'($urandom_range(0, 1));
        2:       out_tready = ($urandom_range(0, 9) != 0);
        default: out_tready = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // One request: drive at the falling edge, hold until accepted at a rising
  // edge. Requests go out in bursts; a new burst may start after a gap, and
  // about a third of the bursts follow the previous one with no gap.
  task automatic put_req(input logic [1:0] op, input logic [BYTE_W-1:0] val);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = val;
    do @(posedge clk); while (!in_tready);
    req_count++;
  endtask

  // random byte that neither opens nor closes a frame
  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(0, 255)); while (b == head_val || b == tail_val);
    return b;
  endfunction

  // head, n payload bytes, optional tail; the first payload byte is the
  // detection flag, set to "found" half the time
  task automatic send_frame(input int n_data, input bit closed);
    logic [BYTE_W-1:0] b;
    put_req(OP_BYTE, head_val);
    for (int i = 0; i < n_data; i++) begin
      b = plain_byte();
      if (i == 0 && $urandom_range(0, 1)) b = DETECT_FOUND;
      put_req(OP_BYTE, b);
    end
    if (closed) put_req(OP_BYTE, tail_val);
  endtask

  task automatic send_mode();
    if ($urandom_range(0, 9) < 8) put_req(OP_MODE, mode_chars[$urandom_range(0, 3)]);
    else put_req(OP_MODE, BYTE_W'($urandom_range(0, 255)));
  endtask

  // Mostly well-formed frames (usually the full four payload bytes) and
  // mode switches; the rest is noise: raw requests of any op, a head byte
  // inside a frame, a stray tail, and runs long enough to overflow.
  task automatic random_item();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      send_frame(($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 4, 1'b1);
    end else if (sel < 78) begin
      send_mode();
    end else if (sel < 86) begin
      put_req(2'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)));
    end else if (sel < 90) begin
      put_req(OP_BYTE, head_val);
      put_req(OP_BYTE, plain_byte());
      put_req(OP_BYTE, head_val);
      put_req(OP_BYTE, plain_byte());
      put_req(OP_BYTE, tail_val);
    end else if (sel < 94) begin
      put_req(OP_BYTE, tail_val);
    end else begin
      send_frame($urandom_range(5, 7), 1'($urandom_range(0, 1)));
    end
  endtask

  // register writes only with nothing in flight
  task automatic settle();
    @(negedge clk);
    in_tvalid  = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [BYTE_W-1:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (idx == CFG_HEAD) head_val = val;
    else tail_val = val;
  endtask

  initial begin : stimulus
    int target;
    logic [BYTE_W-1:0] h;
    logic [BYTE_W-1:0] t;
    rst_n     = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_HEAD;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_BYTE;
    head_val  = HEAD_RESET;
    tail_val  = TAIL_RESET;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // --- directed part, reset register values (head 10, tail 0) ---
    put_req(OP_BYTE, TAIL_RESET);        // tail while idle, reset mode: no change
    put_req(OP_MODE, CHAR_L);
    put_req(OP_BYTE, HEAD_RESET);        // location frame with extreme coordinates
    put_req(OP_BYTE, 8'd1);
    put_req(OP_BYTE, 8'd255);
    put_req(OP_BYTE, 8'd254);
    put_req(OP_BYTE, TAIL_RESET);
    put_req(OP_BYTE, HEAD_RESET);        // head inside a frame, then overflow
    put_req(OP_BYTE, 8'd5);
    put_req(OP_BYTE, HEAD_RESET);
    put_req(OP_BYTE, 8'd7);
    put_req(OP_BYTE, 8'd8);
    put_req(OP_BYTE, 8'd9);
    put_req(OP_MODE, CHAR_D);            // detection find: sticky flag, 'R' sent
    put_req(OP_BYTE, HEAD_RESET);
    put_req(OP_BYTE, DETECT_FOUND);
    put_req(OP_BYTE, 8'd200);
    put_req(OP_BYTE, 8'd100);
    put_req(OP_BYTE, TAIL_RESET);
    put_req(OP_MODE, CHAR_F);            // put mode, tail while idle decodes store
    put_req(OP_BYTE, TAIL_RESET);
    put_req(OP_MODE, 8'hFF);             // unknown mode char: echoed only
    put_req(OP_UART, 8'h55);
    put_req(OP_SPARE, 8'hAA);
    settle();

    // --- random part, one register setting per phase ---
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        case (phase)
          1:       begin h = 8'h00; t = 8'hFF; end
          2:       begin h = 8'hFF; t = 8'h00; end
          3:       begin h = 8'h7E; t = 8'h7E; end   // head equals tail
          default: begin
            h = BYTE_W'($urandom_range(0, 255));
            do t = BYTE_W'($urandom_range(0, 255)); while (t == h);
          end
        endcase
        write_reg(CFG_HEAD, h);
        write_reg(CFG_TAIL, t);
        settings++;
      end
      // long result-side hold-off while requests keep coming
      if (phase == 1 || phase == 3) hold_req = 1'b1;
      target = req_count + PHASE_REQS;
      while (req_count < target) random_item();
      settle();
    end

    repeat (DRAIN) @(negedge clk);
    $display("Covered %0d requests under %0d head/tail settings, %0d results checked.",
             req_count, settings, checked);
    $display("Frames decoded: %0d, overflows: %0d, detection finds: %0d.",
             frames, overflows, finds);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
